[hdl/number_to_ascii_formatter_unit_defines.svh]
// Assertion macros shared by the checker of the number formatter.
// Each macro samples on clk and is disabled while rst is high.
`ifndef NUMBER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NAFMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NAFMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/nafmt_pkg.sv]
package nafmt_pkg;

  localparam int ModeW  = 3;
  localparam int ValueW = 32;
  localparam int CharW  = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_UDEC = 3'd0,
    MODE_SDEC = 3'd1,
    MODE_OCT  = 3'd2,
    MODE_HEXL = 3'd3,
    MODE_HEXU = 3'd4,
    MODE_BYTE = 3'd5,
    MODE_CHAR = 3'd6,
    MODE_BAD  = 3'd7
  } mode_t;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] ChO     = 8'h6F;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChQuery = 8'h3F;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;

  // ASCII text of one digit; digits of ten and more become letters.
  function automatic logic [CharW-1:0] hex_digit(logic [3:0] nib, logic upper);
    logic [CharW-1:0] base;
    base = upper ? ChUpA : ChLoA;
    if (nib < 4'd10) begin
      hex_digit = ChZero + {4'd0, nib};
    end else begin
      hex_digit = base + {4'd0, nib - 4'd10};
    end
  endfunction

endpackage

[hdl/nafmt_in_if.sv]
interface nafmt_in_if
  import nafmt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

[hdl/nafmt_out_if.sv]
interface nafmt_out_if
  import nafmt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

[hdl/number_to_ascii_formatter_unit.sv]
// Number to ASCII formatter.
// The item channel takes one request: a 32-bit value and a conversion mode
// (unsigned or signed decimal, octal with "0o", lower or upper hex with "0x"
// and eight digits, one uppercase hex byte with "0x", a raw character).
// The text channel returns the characters of that value one per request,
// most significant digit first, with last set on the final character.
// Decimal and octal drop leading zeros; a zero value prints a single '0'.
// Only one value is in work at a time: item.ready is high only while the
// sequencer is idle. A decimal value first runs through the shared
// shift-and-add-3 unit (binary to BCD), then drops its leading zeros one
// at a time, then sends one character per cycle while the receiver keeps
// up. Dropped zeros and digits always add up to ten. Octal drops its
// leading zeros the same way but skips the conversion, hex keeps all its
// digits, and a raw character is sent alone. The unused mode answers
// with a single '?' marked last.
// The last character sits in the output register while the next request is
// taken. When the receiver stalls, the sequencer holds in its current
// character state until the output register frees up; nothing is dropped.
// A synchronous reset returns the sequencer to idle and empties the output
// register.
module number_to_ascii_formatter_unit
  import nafmt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  nafmt_in_if.sink          item,
  nafmt_out_if.source       text
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CONV  = 7'b0000010,
    S_SKIP  = 7'b0000100,
    S_PRE0  = 7'b0001000,
    S_PRE1  = 7'b0010000,
    S_DIGIT = 7'b0100000,
    S_CHAR  = 7'b1000000
  } state_t;

  localparam int NumNib = 11;
  localparam int DigW   = 4 * NumNib;

  state_t            state;
  logic [DigW-1:0]   digs;      // digits, left aligned, one per nibble
  logic [ValueW-1:0] bin;       // binary value shifted into the BCD field
  logic [4:0]        cnt;       // conversion step
  logic [3:0]        ndig;      // digits still to send
  logic              neg;       // prefix is a minus sign
  logic              pre_on;    // text has a prefix
  logic              pre_two;   // prefix is "0x" or "0o"
  logic              xch;       // prefix letter is 'x'
  logic              upper;
  logic              sup;       // drop leading zeros
  logic [CharW-1:0]  raw;

  logic              ovalid;
  logic [CharW-1:0]  ochar;
  logic              olast;

  logic              emit;
  logic              load;
  logic [DigW-1:0]   oct_digs;
  logic [ValueW:0]   vpad;
  logic [39:0]       bcd_adj;

  // Start values for a new request, decoded from its mode.
  state_t            st_state;
  logic [DigW-1:0]   st_digs;
  logic [ValueW-1:0] st_bin;
  logic [3:0]        st_ndig;
  logic              st_neg;
  logic              st_pre_on;
  logic              st_pre_two;
  logic              st_xch;
  logic              st_upper;
  logic              st_sup;
  logic [CharW-1:0]  st_raw;

  assign item.ready     = (state == S_IDLE);
  assign text.valid     = ovalid;
  assign text.char_code = ochar;
  assign text.last      = olast;

  // The output register can take a new character when it is empty or is
  // being handed over in this cycle.
  assign emit = !ovalid || text.ready;
  // A character state writes the output register whenever it can.
  assign load = emit && (state inside {S_PRE0, S_PRE1, S_DIGIT, S_CHAR});

  // Octal digits spread one per nibble; the top one holds only two bits.
  assign vpad = {1'b0, item.value};
  always_comb begin
    for (int i = 0; i < NumNib; i++) begin
      oct_digs[4*i +: 4] = {1'b0, vpad[3*i +: 3]};
    end
  end

  // Shared double-dabble unit: every BCD digit of five or more gets three
  // added before the whole field shifts left by one bit.
  always_comb begin
    for (int j = 0; j < 10; j++) begin
      if (digs[4 + 4*j +: 4] >= 4'd5) begin
        bcd_adj[4*j +: 4] = digs[4 + 4*j +: 4] + 4'd3;
      end else begin
        bcd_adj[4*j +: 4] = digs[4 + 4*j +: 4];
      end
    end
  end

  // Mode decode for the request on the item channel.
  always_comb begin
    st_state   = S_CHAR;
    st_digs    = '0;
    st_bin     = item.value;
    st_ndig    = 4'd10;
    st_neg     = 1'b0;
    st_pre_on  = 1'b0;
    st_pre_two = 1'b0;
    st_xch     = 1'b0;
    st_upper   = 1'b0;
    st_sup     = 1'b0;
    st_raw     = ChQuery;
    case (mode_t'(item.mode))
      MODE_UDEC: begin
        st_sup   = 1'b1;
        st_state = S_CONV;
      end
      MODE_SDEC: begin
        st_sup    = 1'b1;
        st_neg    = item.value[ValueW-1];
        st_pre_on = item.value[ValueW-1];
        if (item.value[ValueW-1]) begin
          st_bin = ~item.value + 32'd1;
        end
        st_state = S_CONV;
      end
      MODE_OCT: begin
        st_digs    = oct_digs;
        st_ndig    = 4'd11;
        st_sup     = 1'b1;
        st_pre_on  = 1'b1;
        st_pre_two = 1'b1;
        st_state   = S_SKIP;
      end
      MODE_HEXL, MODE_HEXU: begin
        st_digs    = {item.value, 12'd0};
        st_ndig    = 4'd8;
        st_pre_on  = 1'b1;
        st_pre_two = 1'b1;
        st_xch     = 1'b1;
        st_upper   = (mode_t'(item.mode) == MODE_HEXU);
        st_state   = S_SKIP;
      end
      MODE_BYTE: begin
        st_digs    = {item.value[7:0], 36'd0};
        st_ndig    = 4'd2;
        st_pre_on  = 1'b1;
        st_pre_two = 1'b1;
        st_xch     = 1'b1;
        st_upper   = 1'b1;
        st_state   = S_SKIP;
      end
      MODE_CHAR: begin
        st_raw   = item.value[7:0];
        st_state = S_CHAR;
      end
      default: begin
        st_state = S_CHAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
      end else if (text.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            neg     <= st_neg;
            pre_on  <= st_pre_on;
            pre_two <= st_pre_two;
            xch     <= st_xch;
            upper   <= st_upper;
            sup     <= st_sup;
            cnt     <= '0;
            digs    <= st_digs;
            bin     <= st_bin;
            ndig    <= st_ndig;
            raw     <= st_raw;
            state   <= st_state;
          end
        end
        S_CONV: begin
          digs[DigW-1:4] <= {bcd_adj[38:0], bin[ValueW-1]};
          bin            <= {bin[ValueW-2:0], 1'b0};
          cnt            <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (sup && digs[DigW-1 -: 4] == 4'd0 && ndig > 4'd1) begin
            digs <= {digs[DigW-5:0], 4'd0};
            ndig <= ndig - 4'd1;
          end else if (pre_on) begin
            state <= S_PRE0;
          end else begin
            state <= S_DIGIT;
          end
        end
        S_PRE0: begin
          if (emit) begin
            ochar  <= neg ? ChMinus : ChZero;
            olast  <= 1'b0;
            state  <= pre_two ? S_PRE1 : S_DIGIT;
          end
        end
        S_PRE1: begin
          if (emit) begin
            ochar  <= xch ? ChX : ChO;
            olast  <= 1'b0;
            state  <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (emit) begin
            ochar  <= hex_digit(digs[DigW-1 -: 4], upper);
            olast  <= (ndig == 4'd1);
            digs   <= {digs[DigW-5:0], 4'd0};
            ndig   <= ndig - 4'd1;
            if (ndig == 4'd1) begin
              state <= S_IDLE;
            end
          end
        end
        S_CHAR: begin
          if (emit) begin
            ochar  <= raw;
            olast  <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/nafmt_chk.sv]
`include "number_to_ascii_formatter_unit_defines.svh"

module nafmt_chk
  import nafmt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [ModeW-1:0]  in_mode,
  input logic [ValueW-1:0] in_value,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CharW-1:0]  out_char,
  input logic              out_last
);

  // A stalled character must not change.
  `NAFMT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last), "stalled character changed")

  // Once a value is taken, the block is busy in the next cycle.
  `NAFMT_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready right after a request")

  // A raw character taken while the output is empty comes out after the S_CHAR state, alone and marked last.
  `NAFMT_ASSERT_IMP(a_raw_char, in_valid && in_ready && in_mode == MODE_CHAR && !out_valid, ##2 (out_valid && out_last && out_char == $past(in_value[7:0], 2)), "raw character wrong")

  // The unused mode answers with a single question mark.
  `NAFMT_ASSERT_IMP(a_bad_mode, in_valid && in_ready && in_mode == MODE_BAD && !out_valid, ##2 (out_valid && out_last && out_char == ChQuery), "unused mode not answered")

endmodule

bind number_to_ascii_formatter_unit nafmt_chk u_nafmt_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_mode   (item.mode),
  .in_value  (item.value),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .out_char  (text.char_code),
  .out_last  (text.last)
);
